// File: rtl/xxh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xxh_pkg
// Constants, types and helper functions shared by the XXH64 stream hash.
// ----------------------------------------------------------------------------
package xxh_pkg;

  localparam logic [63:0] P1  = 64'h9E3779B185EBCA87;
  localparam logic [63:0] P2  = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] P3  = 64'h165667B19E3779F9;
  localparam logic [63:0] P4  = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] P5  = 64'h27D4EB2F165667C5;
  localparam logic [63:0] P12 = P1 + P2;

  localparam logic [3:0] WORD_BYTES = 4'd8;

  // Register index of the seed in the configuration map.
  localparam logic REG_SEED = 1'b0;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOAD,
    S_LR1,
    S_LR2,
    S_CONV,
    S_FL1,
    S_FL2,
    S_FL3,
    S_LEN,
    S_TSEL,
    S_T8A,
    S_T8B,
    S_T8C,
    S_T4A,
    S_T4B,
    S_T1A,
    S_T1B,
    S_AV1,
    S_AV2,
    S_OUT
  } seq_state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last;
  } in_beat_t;

  function automatic logic [63:0] rol64(input logic [63:0] v, input logic [5:0] s);
    return (v << s) | (v >> (7'd64 - {1'b0, s}));
  endfunction

endpackage
`default_nettype wire

// File: rtl/xxh_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xxh_mul
// Iterative 64 x 64 multiplier giving the low 64 bits of the product. One
// 32 x 32 multiplier forms three partial products in turn.
// ----------------------------------------------------------------------------
module xxh_mul
  import xxh_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mul_req_t req,
  output mul_rsp_t      rsp
);

  localparam logic [1:0] LAST_STEP = 2'd2;

  logic        busy_r;
  logic [1:0]  step_r;
  logic        done_r;
  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] acc_r;

  logic [31:0] x;
  logic [31:0] y;
  logic [63:0] prod;
  logic [63:0] acc_nxt;

  always_comb begin
    case (step_r)
      2'd0: begin
        x = a_r[31:0];
        y = b_r[31:0];
      end
      2'd1: begin
        x = a_r[31:0];
        y = b_r[63:32];
      end
      default: begin
        x = a_r[63:32];
        y = b_r[31:0];
      end
    endcase
  end

  assign prod    = x * y;
  assign acc_nxt = (step_r == 2'd0) ? prod
                                    : {acc_r[63:32] + prod[31:0], acc_r[31:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 2'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (step_r == LAST_STEP);
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        step_r <= 2'd0;
      end else if (busy_r) begin
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
        end else begin
          step_r <= step_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      a_r <= req.a;
      b_r <= req.b;
    end
    if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = acc_r;

endmodule
`default_nettype wire

// File: rtl/xxh_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xxh_seq
// Sequencer and datapath: tail store, lane accumulators, stripe rounds,
// convergence, tail folding and avalanche, all on the shared multiplier.
// ----------------------------------------------------------------------------
module xxh_seq
  import xxh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [63:0] seed,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_beat_t    in_beat,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic [63:0]      res_hash,
  output mul_req_t         mul_req,
  input  wire mul_rsp_t    mul_rsp
);

  seq_state_t  state_r, state_nxt;
  logic        issued_r, issued_nxt;
  logic [1:0]  k_r, k_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [4:0]  fill_r, fill_nxt;
  logic [63:0] total_r, total_nxt;
  logic        seen_r, seen_nxt;
  logic        last_r, last_nxt;
  logic [63:0] h_r, h_nxt;
  logic [63:0] t_r, t_nxt;
  logic [63:0] lane_r [4];
  logic [63:0] tail_r [4];

  logic        tail_we;
  logic        lane_we;
  logic        lane_load;

  logic        accept;
  logic [3:0]  n_sat;
  logic [3:0]  n;
  logic [63:0] word_masked;
  logic [5:0]  fill_sum;
  logic [1:0]  rd_idx;
  logic [63:0] rd_word;
  logic [63:0] byte_shift;
  logic [63:0] lane_rd;
  logic [63:0] conv;
  logic [5:0]  pos6;
  logic [5:0]  fill6;
  logic        mul_state;
  logic        done;
  logic [63:0] m;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign m        = mul_rsp.p;
  assign done     = mul_rsp.done && issued_r;

  assign n_sat = (in_beat.byte_count > WORD_BYTES) ? WORD_BYTES : in_beat.byte_count;
  assign n     = in_beat.last ? n_sat : WORD_BYTES;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      word_masked[8*i +: 8] = (i < int'(n)) ? in_beat.data_word[8*i +: 8] : 8'h00;
    end
  end

  assign fill_sum   = {1'b0, fill_r} + {2'b00, n};
  assign rd_idx     = (state_r == S_LR1) ? k_r : pos_r[4:3];
  assign rd_word    = tail_r[rd_idx];
  assign byte_shift = rd_word >> {pos_r[2:0], 3'b000};
  assign lane_rd    = lane_r[k_r];
  assign pos6       = {1'b0, pos_r};
  assign fill6      = {1'b0, fill_r};
  assign conv       = rol64(lane_r[0], 6'd1) + rol64(lane_r[1], 6'd7)
                    + rol64(lane_r[2], 6'd12) + rol64(lane_r[3], 6'd18);

  assign mul_state = state_r inside {S_LR1, S_LR2, S_FL1, S_FL2, S_FL3, S_T8A, S_T8B,
                                     S_T8C, S_T4A, S_T4B, S_T1A, S_T1B, S_AV1, S_AV2};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (fill_sum[5]) begin
            state_nxt = seen_r ? S_LR1 : S_LOAD;
          end else if (in_beat.last) begin
            state_nxt = S_CONV;
          end
        end
      end
      S_LOAD: state_nxt = S_LR1;
      S_LR1:  if (done) state_nxt = S_LR2;
      S_LR2: begin
        if (done) begin
          if (k_r == 2'd3) begin
            state_nxt = last_r ? S_CONV : S_IDLE;
          end else begin
            state_nxt = S_LR1;
          end
        end
      end
      S_CONV: state_nxt = seen_r ? S_FL1 : S_LEN;
      S_FL1:  if (done) state_nxt = S_FL2;
      S_FL2:  if (done) state_nxt = S_FL3;
      S_FL3:  if (done) state_nxt = (k_r == 2'd3) ? S_LEN : S_FL1;
      S_LEN:  state_nxt = S_TSEL;
      S_TSEL: begin
        if (pos6 + 6'd8 <= fill6) begin
          state_nxt = S_T8A;
        end else if (pos6 + 6'd4 <= fill6) begin
          state_nxt = S_T4A;
        end else if (pos6 < fill6) begin
          state_nxt = S_T1A;
        end else begin
          state_nxt = S_AV1;
        end
      end
      S_T8A:  if (done) state_nxt = S_T8B;
      S_T8B:  if (done) state_nxt = S_T8C;
      S_T8C:  if (done) state_nxt = S_TSEL;
      S_T4A:  if (done) state_nxt = S_T4B;
      S_T4B:  if (done) state_nxt = S_TSEL;
      S_T1A:  if (done) state_nxt = S_T1B;
      S_T1B:  if (done) state_nxt = S_TSEL;
      S_AV1:  if (done) state_nxt = S_AV2;
      S_AV2:  if (done) state_nxt = S_OUT;
      S_OUT:  if (res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    issued_nxt    = issued_r;
    k_nxt         = k_r;
    pos_nxt       = pos_r;
    fill_nxt      = fill_r;
    total_nxt     = total_r;
    seen_nxt      = seen_r;
    last_nxt      = last_r;
    h_nxt         = h_r;
    t_nxt         = t_r;
    tail_we       = 1'b0;
    lane_we       = 1'b0;
    lane_load     = 1'b0;
    res_valid     = 1'b0;
    mul_req.start = mul_state && !issued_r;
    mul_req.a     = h_r;
    mul_req.b     = P1;

    if (mul_req.start) begin
      issued_nxt = 1'b1;
    end else if (done) begin
      issued_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          last_nxt = in_beat.last;
          if (n != 4'd0) begin
            tail_we   = 1'b1;
            fill_nxt  = fill_sum[4:0];
            total_nxt = total_r + {60'd0, n};
          end
        end
      end
      S_LOAD: lane_load = 1'b1;
      S_LR1: begin
        mul_req.a = rd_word;
        mul_req.b = P2;
        if (done) t_nxt = rol64(lane_rd + m, 6'd31);
      end
      S_LR2: begin
        mul_req.a = t_r;
        if (done) begin
          lane_we = 1'b1;
          k_nxt   = k_r + 2'd1;
          if (k_r == 2'd3) begin
            fill_nxt = 5'd0;
            seen_nxt = 1'b1;
          end
        end
      end
      S_CONV: begin
        pos_nxt = 5'd0;
        k_nxt   = 2'd0;
        h_nxt   = seen_r ? conv : seed + P5;
      end
      S_FL1: begin
        mul_req.a = lane_rd;
        mul_req.b = P2;
        if (done) t_nxt = rol64(m, 6'd31);
      end
      S_FL2: begin
        mul_req.a = t_r;
        if (done) h_nxt = h_r ^ m;
      end
      S_FL3: begin
        if (done) begin
          h_nxt = m + P4;
          k_nxt = k_r + 2'd1;
        end
      end
      S_LEN:  h_nxt = h_r + total_r;
      S_TSEL: begin
      end
      S_T8A: begin
        mul_req.a = rd_word;
        mul_req.b = P2;
        if (done) t_nxt = rol64(m, 6'd31);
      end
      S_T8B: begin
        mul_req.a = t_r;
        if (done) h_nxt = h_r ^ m;
      end
      S_T8C: begin
        mul_req.a = rol64(h_r, 6'd27);
        if (done) begin
          h_nxt   = m + P4;
          pos_nxt = pos_r + 5'd8;
        end
      end
      S_T4A: begin
        mul_req.a = {32'd0, rd_word[31:0]};
        if (done) h_nxt = h_r ^ m;
      end
      S_T4B: begin
        mul_req.a = rol64(h_r, 6'd23);
        mul_req.b = P2;
        if (done) begin
          h_nxt   = m + P3;
          pos_nxt = pos_r + 5'd4;
        end
      end
      S_T1A: begin
        mul_req.a = {56'd0, byte_shift[7:0]};
        mul_req.b = P5;
        if (done) h_nxt = h_r ^ m;
      end
      S_T1B: begin
        mul_req.a = rol64(h_r, 6'd11);
        if (done) begin
          h_nxt   = m;
          pos_nxt = pos_r + 5'd1;
        end
      end
      S_AV1: begin
        mul_req.a = h_r ^ (h_r >> 33);
        mul_req.b = P2;
        if (done) h_nxt = m;
      end
      S_AV2: begin
        mul_req.a = h_r ^ (h_r >> 29);
        mul_req.b = P3;
        if (done) h_nxt = m ^ (m >> 32);
      end
      S_OUT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          total_nxt = 64'd0;
          fill_nxt  = 5'd0;
          seen_nxt  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign res_hash = h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      issued_r <= 1'b0;
      k_r      <= 2'd0;
      pos_r    <= 5'd0;
      fill_r   <= 5'd0;
      total_r  <= 64'd0;
      seen_r   <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;
      k_r      <= k_nxt;
      pos_r    <= pos_nxt;
      fill_r   <= fill_nxt;
      total_r  <= total_nxt;
      seen_r   <= seen_nxt;
      last_r   <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r <= h_nxt;
    t_r <= t_nxt;
    if (tail_we) begin
      tail_r[fill_r[4:3]] <= word_masked;
    end
    if (lane_load) begin
      lane_r[0] <= seed + P12;
      lane_r[1] <= seed + P2;
      lane_r[2] <= seed;
      lane_r[3] <= seed - P1;
    end else if (lane_we) begin
      lane_r[k_r] <= m;
    end
  end

endmodule
`default_nettype wire

// File: rtl/xxh64_stream_hash.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xxh64_stream_hash
// XXH64 digest of a stream of little-endian 8-byte words under a seed that
// is written over an APB-style register port.
// ----------------------------------------------------------------------------
// A word that does not close a 32-byte stripe goes to the tail buffer and,
// unless last, the next word may follow. A word that closes one starts eight
// lane multiplications on the shared multiplier, after the S_LOAD seeding
// state on the first stripe; no word is taken until they are done. After
// the last word the digest takes 12 multiplications to converge after a full
// stripe, 3 per buffered word, 2 for a 4-byte word, 2 per byte, 2 for avalanche.
// Reset clears all control state and the seed; no clearing pass is needed.
module xxh64_stream_hash
  import xxh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // data_word [63:0], byte_count [67:64]
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // hash [63:0]
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [63:0] seed_r;
  logic        out_valid_r;
  logic [63:0] out_hash_r;

  in_beat_t    in_beat;
  mul_req_t    mul_req;
  mul_rsp_t    mul_rsp;
  logic        res_valid;
  logic        res_ready;
  logic [63:0] res_hash;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[3] == REG_SEED) ? seed_r : 64'd0;

  assign in_beat.data_word  = in_tdata[63:0];
  assign in_beat.byte_count = in_tdata[67:64];
  assign in_beat.last       = in_tlast;

  assign res_ready  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_hash_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= 64'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr && (cfg_paddr[3] == REG_SEED)) begin
        seed_r <= cfg_pwdata;
      end
      if (res_valid && res_ready) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_hash_r <= res_hash;
    end
  end

  xxh_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  xxh_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .seed      (seed_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_beat   (in_beat),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_hash  (res_hash),
    .mul_req   (mul_req),
    .mul_rsp   (mul_rsp)
  );

endmodule
`default_nettype wire

// File: tb/sv/xxh64_stream_hash_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xxh64_stream_hash_test
// Self-checking testbench for the XXH64 stream hash. A short table of
// directed beats is followed by random messages under a series of seeds,
// with random gaps on the input and random stalls on the result side. Each
// digest is checked against a behavioural model of the hash kept in this
// file, or against a fixed digest where the value is well known.
// ----------------------------------------------------------------------------
module xxh64_stream_hash_test;
  import xxh_pkg::*;

  localparam logic [3:0]  SEED_ADDR     = {REG_SEED, 3'b000};
  localparam int unsigned NUM_PHASES    = 10;
  localparam int unsigned PHASE_BEATS   = 200;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned PROBE_ROWS    = 17;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  cnt;
    logic        fin;
    logic        pinned;
    logic [63:0] hash;
  } probe_t;

  localparam probe_t PROBES [PROBE_ROWS] = '{
    '{64'h0000_0000_0000_0000, 4'd0,  1'b1, 1'b1, 64'hEF46_DB37_51D8_E999},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, 1'b0, 64'h0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd1,  1'b1, 1'b0, 64'h0},
    '{64'h0123_4567_89AB_CDEF, 4'd15, 1'b0, 1'b0, 64'h0},
    '{64'hFEDC_BA98_7654_3210, 4'd0,  1'b0, 1'b0, 64'h0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd3,  1'b0, 1'b0, 64'h0},
    '{64'h0000_0000_0000_0000, 4'd8,  1'b0, 1'b0, 64'h0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 4'd7,  1'b1, 1'b0, 64'h0},
    '{64'h5555_5555_5555_5555, 4'd0,  1'b0, 1'b0, 64'h0},
    '{64'h8000_0000_0000_0001, 4'd0,  1'b0, 1'b0, 64'h0},
    '{64'h7FFF_FFFF_FFFF_FFFF, 4'd0,  1'b0, 1'b0, 64'h0},
    '{64'hFFFF_FFFF_0000_0001, 4'd4,  1'b1, 1'b0, 64'h0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd9,  1'b0, 1'b0, 64'h0},
    '{64'h0000_0000_0000_0000, 4'd2,  1'b0, 1'b0, 64'h0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  1'b0, 1'b0, 64'h0},
    '{64'h0000_0000_0000_0000, 4'd5,  1'b0, 1'b0, 64'h0},
    '{64'hDEAD_BEEF_0BAD_F00D, 4'd0,  1'b1, 1'b0, 64'h0}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;   // data_word [63:0], byte_count [67:64], zero [71:68]
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // hash [63:0]
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [63:0] cfg_pwdata;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  // Model state of the hash.
  logic [63:0] seed_q;
  logic [63:0] lane [4];
  logic [63:0] stash [4];
  logic [63:0] msg_bytes;
  int unsigned stash_fill;
  bit          stripe_done;

  logic [63:0] digest_q [$];
  logic [63:0] want_hash;
  int unsigned fails;
  int unsigned beats_sent;
  int unsigned messages_sent;
  int unsigned digests_seen;
  int unsigned seeds_used;
  bit          quiet;
  bit          hold_req;

  always #2 clk = ~clk;

  xxh64_stream_hash dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned s);
    return (v << s) | (v >> (64 - s));
  endfunction

  function automatic logic [63:0] mix_round(input logic [63:0] acc, input logic [63:0] w);
    logic [63:0] t;
    t = w * P2;
    t = acc + t;
    return rotl64(t, 31) * P1;
  endfunction

  function automatic void load_lanes();
    lane[0] = seed_q + P1 + P2;
    lane[1] = seed_q + P2;
    lane[2] = seed_q;
    lane[3] = seed_q - P1;
  endfunction

  function automatic void open_message();
    load_lanes();
    msg_bytes   = '0;
    stash_fill  = 0;
    stripe_done = 1'b0;
  endfunction

  // Absorbs one beat; returns 1 with the digest when the beat ends a message.
  function automatic bit digest_step(input logic [63:0] word, input logic [3:0] cnt,
                                     input logic fin, output logic [63:0] digest);
    int unsigned n;
    int unsigned pos;
    logic [63:0] h;
    logic [63:0] t;
    n      = 8;
    digest = '0;
    if (fin) begin
      n = (cnt > 4'd8) ? 8 : int'(cnt);
      if (n < 8) word = word & ((64'd1 << (n * 8)) - 64'd1);
    end
    if (n > 0) begin
      stash[(stash_fill >> 3) & 3] = word;
      stash_fill += n;
      msg_bytes  += 64'(n);
      if (stash_fill >= 32) begin
        if (!stripe_done) load_lanes();
        for (int k = 0; k < 4; k++) lane[k] = mix_round(lane[k], stash[k]);
        stripe_done = 1'b1;
        stash_fill  = 0;
      end
    end
    if (!fin) return 1'b0;
    if (stripe_done) begin
      h = rotl64(lane[0], 1) + rotl64(lane[1], 7) + rotl64(lane[2], 12) + rotl64(lane[3], 18);
      for (int k = 0; k < 4; k++) h = (h ^ mix_round(64'd0, lane[k])) * P1 + P4;
    end else begin
      h = seed_q + P5;
    end
    h   = h + msg_bytes;
    pos = 0;
    while (pos + 8 <= stash_fill) begin
      h   = h ^ mix_round(64'd0, stash[pos >> 3]);
      h   = rotl64(h, 27) * P1 + P4;
      pos += 8;
    end
    if (pos + 4 <= stash_fill) begin
      t   = {32'd0, stash[pos >> 3][31:0]};
      h   = h ^ (t * P1);
      h   = rotl64(h, 23) * P2 + P3;
      pos += 4;
    end
    while (pos < stash_fill) begin
      t = (stash[pos >> 3] >> ((pos % 8) * 8)) & 64'hFF;
      h = h ^ (t * P5);
      h = rotl64(h, 11) * P1;
      pos++;
    end
    h = h ^ (h >> 33);
    h = h * P2;
    h = h ^ (h >> 29);
    h = h * P3;
    h = h ^ (h >> 32);
    digest = h;
    open_message();
    return 1'b1;
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_beat(input logic [63:0] word, input logic [3:0] cnt, input logic fin,
                           input logic pinned, input logic [63:0] pinned_hash);
    logic [63:0] calc;
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, cnt, word};
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
    if (digest_step(word, cnt, fin, calc)) begin
      digest_q.push_back(pinned ? pinned_hash : calc);
      messages_sent++;
    end
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic send_message();
    int unsigned r;
    int unsigned nbytes;
    int unsigned full;
    int unsigned tailn;
    logic [3:0]  cnt;
    r = $urandom_range(0, 99);
    if (r < 70) nbytes = $urandom_range(0, 40);
    else if (r < 95) nbytes = $urandom_range(41, 130);
    else nbytes = $urandom_range(131, 300);
    full  = nbytes / 8;
    tailn = nbytes % 8;
    if (tailn == 0 && full > 0 && $urandom_range(0, 1) == 1) begin
      full--;
      tailn = 8;
    end
    for (int k = 0; k < full; k++) send_beat(rand_word(), 4'($urandom_range(0, 15)), 1'b0, 1'b0, '0);
    cnt = 4'(tailn);
    if (tailn == 8 && $urandom_range(0, 3) == 0) cnt = 4'($urandom_range(9, 15));
    send_beat(rand_word(), cnt, 1'b1, 1'b0, '0);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_seed_reg();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= SEED_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== seed_q) begin
      $error("seed readback mismatch: expected %h, actual %h", seed_q, cfg_prdata);
      fails++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic program_seed(input logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= SEED_ADDR;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    seed_q = value;
    seeds_used++;
    @(posedge clk);
    check_seed_reg();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_q.size() == 0) begin
        $error("hash arrived with none pending: actual %h", out_tdata);
        fails++;
      end else begin
        want_hash = digest_q.pop_front();
        digests_seen++;
        if (out_tdata !== want_hash) begin
          $error("hash mismatch: expected %h, actual %h", want_hash, out_tdata);
          fails++;
        end
      end
    end
  end

  initial begin : result_side
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #12_000_000;
    $display("xxh64_stream_hash regression: fail");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase_end;
    logic [63:0] seed_val;
    fails         = 0;
    beats_sent    = 0;
    messages_sent = 0;
    digests_seen  = 0;
    seeds_used    = 0;
    quiet         = 1'b0;
    hold_req      = 1'b0;
    seed_q        = '0;
    stash         = '{default: '0};
    open_message();
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tlast    <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    check_seed_reg();

    for (int i = 0; i < PROBE_ROWS; i++)
      send_beat(PROBES[i].word, PROBES[i].cnt, PROBES[i].fin, PROBES[i].pinned, PROBES[i].hash);
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       seed_val = '1;
        1:       seed_val = '0;
        2:       seed_val = 64'd1;
        3:       seed_val = 64'h8000_0000_0000_0000;
        4:       seed_val = 64'h7FFF_FFFF_FFFF_FFFF;
        default: seed_val = {$urandom, $urandom};
      endcase
      program_seed(seed_val);
      quiet = (p == NUM_PHASES - 1);
      if (p == 2) hold_req = 1'b1;
      phase_end = beats_sent + PHASE_BEATS;
      while (beats_sent < phase_end) send_message();
      // Leave a message open so that the next seed lands in the middle of it.
      if (p % 3 == 1) begin
        repeat ($urandom_range(1, 9)) send_beat(rand_word(), 4'($urandom_range(0, 15)), 1'b0, 1'b0, '0);
      end
      settle();
    end

    $display("Run covered %0d input beats and %0d messages under %0d seed settings; %0d digests checked.",
             beats_sent, messages_sent, seeds_used, digests_seen);
    $display("The result side was held off once for %0d cycles while beats kept arriving.",
             HOLD_CYCLES);
    if (fails == 0) begin
      $display("xxh64_stream_hash regression: pass");
    end else begin
      $display("xxh64_stream_hash regression: fail");
    end
    $finish;
  end

endmodule
